FILE: rtl/core/sptrm_pkg.sv
package sptrm_pkg;

	localparam int VAL_W     = 32;
	localparam int IDX_W     = 10;
	// floor log2 of a range length of up to IDX_W+1 bits
	localparam int LEN_LOG_W = $clog2(IDX_W + 1);

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	localparam logic KIND_BUILD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef logic signed [VAL_W-1:0] val_t;

	function automatic val_t smin(input val_t a, input val_t b);
		return (a <= b) ? a : b;
	endfunction

endpackage

FILE: rtl/core/sptrm_ram.sv
module sptrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: rtl/core/sparse_table_range_min.sv
// Loads: one per cycle, busy stays low; no result except an overflow flag, next cycle.
// Query: reads registered on accept, result set in S_QCMP; rejects strobe next cycle.
// Build after last load: each level k runs S_BCHK, S_BWR per entry, then a closing S_BCHK.
// Single min unit and 2-read table RAM: a new query waits until S_QCMP returns to idle.
// Reset clears the element count and the ready flag; table contents stay undefined.
// The receiver cannot stall: each result is strobed by done for a single cycle.
module sparse_table_range_min
	import sptrm_pkg::*;
#(
	parameter int DEPTH  = 1024,
	parameter int LEVELS = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             req_type,
	input  val_t             value,
	input  logic             last_value,
	input  logic [IDX_W-1:0] left_index,
	input  logic [IDX_W-1:0] right_index,
	output logic             done,
	output val_t             minimum,
	output logic             kind,
	output logic             error
);

	// entry index, count, level widths
	localparam int AW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int LW      = $clog2(LEVELS + 1);
	localparam int KA      = $clog2(LEVELS);
	// wide enough for j + 2^k with k up to LEVELS
	localparam int SW      = CW + LEVELS + 1;
	// table is laid out as {level, entry}
	localparam int RAM_D   = LEVELS << AW;
	localparam int RAM_AW  = KA + AW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_QCMP,   // query read data back, compare
		S_BCHK,   // build: bounds check, issue two reads
		S_BWR     // build: compare and write level entry
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic            ready_q;
	logic            ovf_q;     // overflow seen on the last load, carried to the report
	logic [LW-1:0]   k_q;
	logic [AW-1:0]   j_q;
	logic            done_q;
	val_t            minimum_q;
	logic            kind_q;
	logic            error_q;

	// table RAM ports
	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	val_t              ram_wdata;
	logic [RAM_AW-1:0] ram_raddr_a;
	logic [RAM_AW-1:0] ram_raddr_b;
	val_t              rd_a;
	val_t              rd_b;

	// shared compare unit: serves both the build and the query
	val_t min_w;
	assign min_w = smin(rd_a, rd_b);

	logic accept;
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// load path: a load after a build restarts the array
	logic [CW-1:0] cnt_eff;
	logic          ovf_w;
	assign cnt_eff = ready_q ? '0 : count_q;
	assign ovf_w   = (cnt_eff >= CW'(DEPTH));

	// query path
	logic [IDX_W:0]     q_len;
	logic [LEN_LOG_W-1:0] q_lg;
	logic [KA-1:0]      q_k;
	logic [IDX_W:0]     q_off;
	logic [IDX_W:0]     q_rstart;
	logic               q_bad;

	function automatic logic [LEN_LOG_W-1:0] flog2(input logic [IDX_W:0] x);
		logic [LEN_LOG_W-1:0] r;
		r = '0;
		for (int i = 0; i <= IDX_W; i++) begin
			if (x[i]) begin
				r = LEN_LOG_W'(i);
			end
		end
		return r;
	endfunction

	always_comb begin
		q_len = {1'b0, right_index} - {1'b0, left_index} + (IDX_W+1)'(1);
		q_lg  = flog2(q_len);
		// level count too small for the range: fall back to the top level
		if (int'(q_lg) > LEVELS - 1) begin
			q_k = KA'(LEVELS - 1);
		end else begin
			q_k = KA'(q_lg);
		end
		q_off    = ((IDX_W+1)'(1) << q_k) - (IDX_W+1)'(1);
		q_rstart = {1'b0, right_index} - q_off;
		q_bad    = !ready_q || (left_index > right_index)
		           || ({{CW{1'b0}}, right_index} >= {{IDX_W{1'b0}}, count_q});
	end

	// build path
	logic [LW-1:0] km1;
	logic [SW-1:0] b_end;
	logic [SW-1:0] b_mate;
	logic          b_fit;

	always_comb begin
		km1    = k_q - LW'(1);
		b_end  = SW'(j_q) + (SW'(1) << k_q);
		b_mate = SW'(j_q) + (SW'(1) << km1);
		b_fit  = (k_q < LW'(LEVELS)) && (b_end <= SW'(count_q));
	end

	// RAM control
	always_comb begin
		ram_we    = (accept && (req_type == REQ_LOAD) && !ovf_w) || (state_q == S_BWR);
		if (state_q == S_BWR) begin
			ram_waddr = {k_q[KA-1:0], j_q};
			ram_wdata = min_w;
		end else begin
			ram_waddr = {KA'(0), cnt_eff[AW-1:0]};
			ram_wdata = value;
		end
		if (state_q == S_BCHK) begin
			ram_raddr_a = {km1[KA-1:0], j_q};
			ram_raddr_b = {km1[KA-1:0], b_mate[AW-1:0]};
		end else begin
			ram_raddr_a = {q_k, AW'(left_index)};
			ram_raddr_b = {q_k, AW'(q_rstart)};
		end
	end

	sptrm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (RAM_D)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ready_q   <= 1'b0;
			ovf_q     <= 1'b0;
			k_q       <= '0;
			j_q       <= '0;
			done_q    <= 1'b0;
			minimum_q <= '0;
			kind_q    <= KIND_BUILD;
			error_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == REQ_LOAD) begin
							ready_q <= 1'b0;
							count_q <= ovf_w ? cnt_eff : cnt_eff + CW'(1);
							if (last_value) begin
								ovf_q   <= ovf_w;
								k_q     <= LW'(1);
								j_q     <= '0;
								state_q <= S_BCHK;
							end else if (ovf_w) begin
								done_q    <= 1'b1;
								kind_q    <= KIND_BUILD;
								error_q   <= 1'b1;
								minimum_q <= '0;
							end
						end else if (q_bad) begin
							done_q    <= 1'b1;
							kind_q    <= KIND_QUERY;
							error_q   <= 1'b1;
							minimum_q <= '0;
						end else begin
							state_q <= S_QCMP;
						end
					end
				end
				S_QCMP: begin
					done_q    <= 1'b1;
					kind_q    <= KIND_QUERY;
					error_q   <= 1'b0;
					minimum_q <= min_w;
					state_q   <= S_IDLE;
				end
				S_BCHK: begin
					if (b_fit) begin
						state_q <= S_BWR;
					end else if ((j_q == '0) || (k_q >= LW'(LEVELS))) begin
						// level k has no entry, or all levels built: table complete
						ready_q   <= 1'b1;
						done_q    <= 1'b1;
						kind_q    <= KIND_BUILD;
						error_q   <= ovf_q;
						minimum_q <= '0;
						state_q   <= S_IDLE;
					end else begin
						k_q <= k_q + LW'(1);
						j_q <= '0;
					end
				end
				S_BWR: begin
					j_q     <= j_q + AW'(1);
					state_q <= S_BCHK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done    = done_q;
	assign minimum = minimum_q;
	assign kind    = kind_q;
	assign error   = error_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while sequencer busy");

	a_answer_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (kind == KIND_QUERY) && !error) |-> $past(state_q == S_QCMP))
		else $error("query answer without table read");

	a_ready_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> $past(state_q == S_BCHK))
		else $error("table marked ready outside build");

	a_wr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BWR) |=> (state_q == S_BCHK) && (j_q == $past(j_q) + AW'(1)))
		else $error("build write did not advance entry index");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= (CW+1)'(DEPTH))
		else $error("element count above depth");
`endif

endmodule
